// ----- hw/rtl/ds_twr_time_of_flight_macros.svh -----
// Assertion macros for the two-way ranging block.
// Define ASSERT_OFF to drop all checks.
`ifndef DS_TWR_TIME_OF_FLIGHT_MACROS_SVH
`define DS_TWR_TIME_OF_FLIGHT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- hw/rtl/dstwr_pkg.sv -----
// Shared types and constants for the two-way ranging block.
// No dependencies.
`default_nettype none
package dstwr_pkg;
  localparam int STAMP_BITS_DEF = 32;
  localparam int SCALE_BITS = 24;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd307479;
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_SAT = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ----- hw/rtl/dstwr_front.sv -----
// Interval, product and denominator stages.
// Depends on dstwr_pkg.
`default_nettype none
module dstwr_front import dstwr_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  localparam int DW = STAMP_BITS + 2,
  localparam int PW = 2 * STAMP_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [31:0] s_poll_tx,
  input  wire logic [31:0] s_resp_rx,
  input  wire logic [31:0] s_final_tx,
  input  wire logic [31:0] s_poll_rx,
  input  wire logic [31:0] s_resp_tx,
  input  wire logic [31:0] s_final_rx,
  output logic out_valid,
  output logic [PW:0] num_mag,
  output logic num_neg,
  output logic [DW-1:0] den
);
  logic v1, v2;
  logic [STAMP_BITS-1:0] ra, rb, da, db;
  logic [PW-1:0] pr, pd;
  logic [DW-1:0] den1;
  logic [PW:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ra <= STAMP_BITS'(s_resp_rx) - STAMP_BITS'(s_poll_tx);
    rb <= STAMP_BITS'(s_final_rx) - STAMP_BITS'(s_resp_tx);
    da <= STAMP_BITS'(s_final_tx) - STAMP_BITS'(s_resp_rx);
    db <= STAMP_BITS'(s_resp_tx) - STAMP_BITS'(s_poll_rx);
    pr <= PW'(ra) * PW'(rb);
    pd <= PW'(da) * PW'(db);
    den1 <= DW'(ra) + DW'(rb) + DW'(da) + DW'(db);
    num_neg <= diff[PW];
    num_mag <= diff[PW] ? (PW+1)'(-diff) : diff;
    den <= den1;
  end

  assign diff = {1'b0, pr} - {1'b0, pd};
endmodule
`default_nettype wire

// ----- hw/rtl/dstwr_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Depends on dstwr_pkg.
`default_nettype none
module dstwr_divider import dstwr_pkg::*; #(
  parameter int NW = 65,
  parameter int DW = 34
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic neg_in,
  input  wire logic [DW-1:0] den_in,
  output logic out_valid,
  output logic [NW-1:0] quo,
  output logic neg_out,
  output logic zero_out
);
  logic [NW:0] v;
  logic [NW-1:0] q [NW+1];
  logic [DW:0] r [NW+1];
  logic [DW-1:0] d [NW+1];
  logic n [NW+1];

  always_comb begin
    v[0] = in_valid;
    q[0] = num;
    r[0] = '0;
    d[0] = den_in;
    n[0] = neg_in;
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] sh;
    logic [DW+1:0] t;
    assign sh = {r[i][DW-1:0], q[i][NW-1]};
    assign t = {1'b0, sh} - {2'b00, d[i]};
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      r[i+1] <= t[DW+1] ? sh : t[DW:0];
      q[i+1] <= {q[i][NW-2:0], ~t[DW+1]};
      d[i+1] <= d[i];
      n[i+1] <= n[i];
    end
  end

  assign out_valid = v[NW];
  assign quo = q[NW];
  assign neg_out = n[NW];
  assign zero_out = (d[NW] == '0);
endmodule
`default_nettype wire

// ----- hw/rtl/dstwr_scale.sv -----
// Saturation and distance scaling stages.
// Depends on dstwr_pkg and the assertion macros.
`include "ds_twr_time_of_flight_macros.svh"
`default_nettype none
module dstwr_scale import dstwr_pkg::*; #(
  parameter int NW = 65
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic [NW-1:0] quo,
  input  wire logic neg,
  input  wire logic zero,
  input  wire logic [SCALE_BITS-1:0] scale,
  output logic out_valid,
  output logic signed [31:0] flight,
  output logic signed [47:0] dist_mm,
  output status_t stat
);
  logic v1, neg1, zero1, sat1;
  logic [31:0] mag1;
  logic [55:0] prod;
  logic [55:0] rnd;
  logic big;

  assign big = (quo[NW-1:32] != '0) ||
               (neg ? (quo[31:0] > 32'h8000_0000) : quo[31]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    neg1 <= neg;
    zero1 <= zero;
    sat1 <= big;
    mag1 <= big ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : quo[31:0];
  end

  assign prod = 56'(mag1) * 56'(scale);
  assign rnd = prod + 56'hFFFF;

  always_ff @(posedge clk) begin
    if (zero1) begin
      flight <= '0;
      dist_mm <= '0;
      stat <= ST_ZERO_DEN;
    end else begin
      flight <= neg1 ? -$signed(mag1) : $signed(mag1);
      dist_mm <= neg1 ? -$signed({8'd0, rnd[55:16]}) : $signed({8'd0, prod[55:16]});
      stat <= sat1 ? ST_SAT : ST_OK;
    end
  end

  `ASSERT_NEVER(a_zero_stat, clk, rst, out_valid && stat == ST_ZERO_DEN && flight != 0,
                "zero denominator with nonzero flight")
  `ASSERT_IMPL(a_valid_follow, clk, rst, v1 |=> out_valid, "lost word in scale stage")
  `ASSERT_NEVER(a_sat_pos, clk, rst,
                out_valid && stat == ST_OK && flight == 32'sh7FFF_FFFF && dist_mm < 0,
                "positive flight gave negative distance")
endmodule
`default_nettype wire

// ----- hw/rtl/ds_twr_time_of_flight.sv -----
// Top level of the two-way ranging time-of-flight block.
// Depends on dstwr_pkg, dstwr_front, dstwr_divider, dstwr_scale.
//
// Takes one exchange per clock (start while busy is low; busy is always low).
// Each result appears on done for one cycle, after the front stages, the
// one-bit-per-stage divider and the scale stages.
// The receiver cannot stall; every result must be taken on its cycle.
`default_nettype none
module ds_twr_time_of_flight import dstwr_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [31:0] remote_poll_sent,
  input  wire logic [31:0] remote_resp_got,
  input  wire logic [31:0] remote_final_sent,
  input  wire logic [31:0] local_poll_got,
  input  wire logic [31:0] local_resp_sent,
  input  wire logic [31:0] local_final_got,
  input  wire logic cfg_we,
  input  wire logic [SCALE_BITS-1:0] cfg_wdata,
  output logic done,
  output logic signed [31:0] flight_units,
  output logic signed [47:0] distance_mm,
  output logic [1:0] status
);
  localparam int DW = STAMP_BITS + 2;
  localparam int NW = 2 * STAMP_BITS + 1;

  logic [SCALE_BITS-1:0] scale;
  logic fv, dv, dneg, dzero, fneg;
  logic [NW-1:0] fnum, dquo;
  logic [DW-1:0] fden;
  status_t stat;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) scale <= SCALE_RESET;
    else if (cfg_we) scale <= cfg_wdata;
  end

  dstwr_front #(.STAMP_BITS(STAMP_BITS)) u_front (
    .clk, .rst, .in_valid(start && !busy),
    .s_poll_tx(remote_poll_sent), .s_resp_rx(remote_resp_got),
    .s_final_tx(remote_final_sent), .s_poll_rx(local_poll_got),
    .s_resp_tx(local_resp_sent), .s_final_rx(local_final_got),
    .out_valid(fv), .num_mag(fnum), .num_neg(fneg), .den(fden)
  );

  dstwr_divider #(.NW(NW), .DW(DW)) u_div (
    .clk, .rst, .in_valid(fv), .num(fnum), .neg_in(fneg), .den_in(fden),
    .out_valid(dv), .quo(dquo), .neg_out(dneg), .zero_out(dzero)
  );

  dstwr_scale #(.NW(NW)) u_scale (
    .clk, .rst, .in_valid(dv), .quo(dquo), .neg(dneg), .zero(dzero),
    .scale, .out_valid(done), .flight(flight_units), .dist_mm(distance_mm),
    .stat
  );

  assign status = stat;
endmodule
`default_nettype wire
